[sv/aps_pkg.sv]
// Shared types and codes for the aging priority scheduler.
package aps_pkg;

    typedef logic [1:0]        action_t;
    typedef logic [1:0]        status_t;
    typedef logic signed [5:0] prio_t;

    localparam action_t ACT_CREATE  = 2'd0;
    localparam action_t ACT_REQUEUE = 2'd1;
    localparam action_t ACT_PICK    = 2'd2;
    localparam action_t ACT_SETPRIO = 2'd3;

    localparam status_t STAT_OK       = 2'd0;
    localparam status_t STAT_EMPTY    = 2'd1;
    localparam status_t STAT_NO_FREE  = 2'd2;
    localparam status_t STAT_BAD_TASK = 2'd3;

    localparam prio_t PRIO_LOW  = -6'sd20;
    localparam prio_t PRIO_HIGH = 6'sd20;

endpackage

[sv/aps_if.sv]
// Request and response channel interfaces of the aging priority scheduler.
interface aps_in_if;
    logic                valid;
    logic                ready;
    aps_pkg::action_t    action;
    logic [3:0]          task_id;
    aps_pkg::prio_t      priority_req;

    modport source (output valid, output action, output task_id, output priority_req,
                    input ready);
    modport sink   (input valid, input action, input task_id, input priority_req,
                    output ready);
endinterface

interface aps_out_if;
    logic                valid;
    logic                ready;
    logic [3:0]          chosen_task;
    logic                chosen_valid;
    aps_pkg::status_t    status;
    aps_pkg::prio_t      static_priority_out;
    logic [4:0]          ready_count;

    modport source (output valid, output chosen_task, output chosen_valid, output status,
                    output static_priority_out, output ready_count, input ready);
    modport sink   (input valid, input chosen_task, input chosen_valid, input status,
                    input static_priority_out, input ready_count, output ready);
endinterface

[sv/aging_priority_scheduler_unit.sv]
// Aging priority scheduler: sequencer, task tables and ready-order memory.
//
// One request word enters on sched_in (action, task_id, priority_req) and one
// response word leaves on sched_out per request. Both channels move a word when
// valid and ready are high at a rising clock edge.
// sched_in.ready is high only while the sequencer is idle; one request is worked
// on at a time. Create, requeue, set priority and a pick on an empty order pass
// through the execute, read and result states before the response is registered.
// A pick walks the ready order once to age every queued entry and choose the
// lowest dynamic priority, then closes the gap left by the removed entry; both
// passes go through the single read port of the ready-order memory.
// The response sits in an output register: the next request is taken while it
// waits, and the sequencer holds its finished result until the register frees
// when the receiver stalls.
// rst_n (asynchronous, active low) empties the ready order, clears all task
// exists and queued flags and the id counter; no clearing pass is needed, the
// priority tables are masked by the exists flags until written.
module aging_priority_scheduler_unit #(
    parameter int MAX_TASKS      = 16,
    parameter int DYN_PRIO_WIDTH = 8
) (
    input  logic      clk,
    input  logic      rst_n,
    aps_in_if.sink    sched_in,
    aps_out_if.source sched_out
);
    import aps_pkg::*;

    localparam int DW    = DYN_PRIO_WIDTH;
    localparam int IDX_W = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
    localparam int CNT_W = $clog2(MAX_TASKS + 1);
    localparam logic [CNT_W-1:0] MAX_CNT = CNT_W'(MAX_TASKS);

    localparam logic [2:0] ST_IDLE  = 3'd0;
    localparam logic [2:0] ST_EXEC  = 3'd1;
    localparam logic [2:0] ST_WALK  = 3'd2;
    localparam logic [2:0] ST_FIX   = 3'd3;
    localparam logic [2:0] ST_SHIFT = 3'd4;
    localparam logic [2:0] ST_READ  = 3'd5;
    localparam logic [2:0] ST_RES   = 3'd6;

    logic [2:0]           state_reg, state_next;
    action_t              act_reg, act_next;
    logic [3:0]           tid_reg, tid_next;
    prio_t                req_reg, req_next;
    logic [CNT_W-1:0]     qlen_reg, qlen_next;
    logic [CNT_W-1:0]     next_id_reg, next_id_next;
    logic [MAX_TASKS-1:0] exists_reg, exists_next;
    logic [MAX_TASKS-1:0] queued_reg, queued_next;
    logic [IDX_W-1:0]     chosen_reg, chosen_next;
    logic                 valid_reg, valid_next;
    status_t              status_reg, status_next;

    logic [CNT_W-1:0]     issue_reg, issue_next;
    logic                 s1_v_reg, s1_v_next;
    logic [IDX_W-1:0]     s1_pos_reg, s1_pos_next;
    logic                 s2_v_reg, s2_v_next;
    logic [IDX_W-1:0]     s2_pos_reg, s2_pos_next;
    logic [IDX_W-1:0]     s2_tid_reg, s2_tid_next;
    logic [IDX_W-1:0]     best_reg, best_next;
    logic [IDX_W-1:0]     best_pos_reg, best_pos_next;
    logic signed [DW-1:0] best_val_reg, best_val_next;
    prio_t                best_stat_reg, best_stat_next;
    logic [CNT_W-1:0]     sh_rd_reg, sh_rd_next;
    logic                 sh_v_reg, sh_v_next;
    logic [IDX_W-1:0]     sh_wr_reg, sh_wr_next;

    logic                 out_valid_reg, out_valid_next;
    logic [3:0]           out_task_reg, out_task_next;
    logic                 out_cv_reg, out_cv_next;
    status_t              out_status_reg, out_status_next;
    prio_t                out_sp_reg, out_sp_next;
    logic [4:0]           out_cnt_reg, out_cnt_next;

    prio_t                stat_mem [MAX_TASKS];
    logic signed [DW-1:0] dyn_mem  [MAX_TASKS];
    logic [IDX_W-1:0]     ro_mem   [MAX_TASKS];

    prio_t                stat_q;
    logic signed [DW-1:0] dyn_q;
    logic [IDX_W-1:0]     ro_q;

    logic                 stat_we;
    logic [IDX_W-1:0]     stat_waddr, stat_raddr;
    prio_t                stat_wdata;
    logic                 dyn_we;
    logic [IDX_W-1:0]     dyn_waddr;
    logic signed [DW-1:0] dyn_wdata;
    logic                 ro_we;
    logic [IDX_W-1:0]     ro_waddr, ro_raddr;
    logic [IDX_W-1:0]     ro_wdata;

    logic                 tid_ok;
    logic [IDX_W-1:0]     tid_idx;
    logic [IDX_W-1:0]     new_id;
    logic                 out_free;
    logic signed [DW-1:0] aged;
    logic                 take;

    assign tid_ok   = int'(tid_reg) < MAX_TASKS;
    assign tid_idx  = IDX_W'(tid_reg);
    assign new_id   = next_id_reg[IDX_W-1:0];
    assign out_free = !out_valid_reg || sched_out.ready;

    assign stat_raddr = (state_reg == ST_WALK) ? ro_q : tid_idx;
    assign ro_raddr   = (state_reg == ST_SHIFT) ? sh_rd_reg[IDX_W-1:0]
                                                : issue_reg[IDX_W-1:0];

    aps_age_unit #(
        .DW (DW)
    ) u_age (
        .cur  (dyn_q),
        .best (best_val_reg),
        .seed (s2_pos_reg == '0),
        .aged (aged),
        .take (take)
    );

    always_ff @(posedge clk)
    begin
        if (stat_we)
        begin
            stat_mem[stat_waddr] <= stat_wdata;
        end
        stat_q <= stat_mem[stat_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (dyn_we)
        begin
            dyn_mem[dyn_waddr] <= dyn_wdata;
        end
        dyn_q <= dyn_mem[ro_q];
    end

    always_ff @(posedge clk)
    begin
        if (ro_we)
        begin
            ro_mem[ro_waddr] <= ro_wdata;
        end
        ro_q <= ro_mem[ro_raddr];
    end

    always_comb
    begin
        state_next      = state_reg;
        act_next        = act_reg;
        tid_next        = tid_reg;
        req_next        = req_reg;
        qlen_next       = qlen_reg;
        next_id_next    = next_id_reg;
        exists_next     = exists_reg;
        queued_next     = queued_reg;
        chosen_next     = chosen_reg;
        valid_next      = valid_reg;
        status_next     = status_reg;
        issue_next      = issue_reg;
        s1_v_next       = s1_v_reg;
        s1_pos_next     = s1_pos_reg;
        s2_v_next       = s2_v_reg;
        s2_pos_next     = s2_pos_reg;
        s2_tid_next     = s2_tid_reg;
        best_next       = best_reg;
        best_pos_next   = best_pos_reg;
        best_val_next   = best_val_reg;
        best_stat_next  = best_stat_reg;
        sh_rd_next      = sh_rd_reg;
        sh_v_next       = sh_v_reg;
        sh_wr_next      = sh_wr_reg;
        out_valid_next  = out_valid_reg && !sched_out.ready;
        out_task_next   = out_task_reg;
        out_cv_next     = out_cv_reg;
        out_status_next = out_status_reg;
        out_sp_next     = out_sp_reg;
        out_cnt_next    = out_cnt_reg;
        stat_we         = 1'b0;
        stat_waddr      = tid_idx;
        stat_wdata      = req_reg;
        dyn_we          = 1'b0;
        dyn_waddr       = tid_idx;
        dyn_wdata       = DW'(req_reg);
        ro_we           = 1'b0;
        ro_waddr        = qlen_reg[IDX_W-1:0];
        ro_wdata        = tid_idx;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (sched_in.valid)
                begin
                    act_next    = sched_in.action;
                    tid_next    = sched_in.task_id;
                    if (sched_in.priority_req < PRIO_LOW)
                    begin
                        req_next = PRIO_LOW;
                    end
                    else if (sched_in.priority_req > PRIO_HIGH)
                    begin
                        req_next = PRIO_HIGH;
                    end
                    else
                    begin
                        req_next = sched_in.priority_req;
                    end
                    chosen_next = '0;
                    valid_next  = 1'b0;
                    status_next = STAT_OK;
                    state_next  = ST_EXEC;
                end
            end
            ST_EXEC:
            begin
                state_next = ST_READ;
                unique case (act_reg)
                    ACT_CREATE:
                    begin
                        if (next_id_reg >= MAX_CNT)
                        begin
                            status_next = STAT_NO_FREE;
                        end
                        else
                        begin
                            next_id_next        = next_id_reg + 1'b1;
                            exists_next[new_id] = 1'b1;
                            stat_we             = 1'b1;
                            stat_waddr          = new_id;
                            stat_wdata          = '0;
                            dyn_we              = 1'b1;
                            dyn_waddr           = new_id;
                            dyn_wdata           = '0;
                            if (qlen_reg < MAX_CNT)
                            begin
                                ro_we               = 1'b1;
                                ro_wdata            = new_id;
                                qlen_next           = qlen_reg + 1'b1;
                                queued_next[new_id] = 1'b1;
                            end
                            chosen_next = new_id;
                            valid_next  = 1'b1;
                        end
                    end
                    ACT_REQUEUE:
                    begin
                        if (!tid_ok || !exists_reg[tid_idx] || queued_reg[tid_idx])
                        begin
                            status_next = STAT_BAD_TASK;
                        end
                        else if (qlen_reg < MAX_CNT)
                        begin
                            ro_we                = 1'b1;
                            qlen_next            = qlen_reg + 1'b1;
                            queued_next[tid_idx] = 1'b1;
                        end
                    end
                    ACT_PICK:
                    begin
                        if (qlen_reg == '0)
                        begin
                            status_next = STAT_EMPTY;
                        end
                        else
                        begin
                            issue_next = '0;
                            s1_v_next  = 1'b0;
                            s2_v_next  = 1'b0;
                            state_next = ST_WALK;
                        end
                    end
                    ACT_SETPRIO:
                    begin
                        if (!tid_ok || !exists_reg[tid_idx])
                        begin
                            status_next = STAT_BAD_TASK;
                        end
                        else
                        begin
                            stat_we = 1'b1;
                            dyn_we  = 1'b1;
                        end
                    end
                    default:
                    begin
                        status_next = STAT_BAD_TASK;
                    end
                endcase
            end
            ST_WALK:
            begin
                // stage 0: order read, stage 1: priority reads, stage 2: age and compare
                if (issue_reg < qlen_reg)
                begin
                    issue_next  = issue_reg + 1'b1;
                    s1_v_next   = 1'b1;
                    s1_pos_next = issue_reg[IDX_W-1:0];
                end
                else
                begin
                    s1_v_next = 1'b0;
                end
                s2_v_next   = s1_v_reg;
                s2_pos_next = s1_pos_reg;
                s2_tid_next = ro_q;
                if (s2_v_reg)
                begin
                    dyn_we    = 1'b1;
                    dyn_waddr = s2_tid_reg;
                    dyn_wdata = aged;
                    if (take)
                    begin
                        best_next      = s2_tid_reg;
                        best_pos_next  = s2_pos_reg;
                        best_val_next  = aged;
                        best_stat_next = stat_q;
                    end
                    if (CNT_W'(s2_pos_reg) == qlen_reg - 1'b1)
                    begin
                        state_next = ST_FIX;
                    end
                end
            end
            ST_FIX:
            begin
                dyn_we                = 1'b1;
                dyn_waddr             = best_reg;
                dyn_wdata             = DW'(best_stat_reg);
                queued_next[best_reg] = 1'b0;
                chosen_next           = best_reg;
                valid_next            = 1'b1;
                sh_rd_next            = CNT_W'(best_pos_reg) + 1'b1;
                sh_v_next             = 1'b0;
                state_next            = ST_SHIFT;
            end
            ST_SHIFT:
            begin
                if (sh_rd_reg < qlen_reg)
                begin
                    sh_v_next  = 1'b1;
                    sh_wr_next = IDX_W'(sh_rd_reg - 1'b1);
                    sh_rd_next = sh_rd_reg + 1'b1;
                end
                else
                begin
                    sh_v_next = 1'b0;
                end
                if (sh_v_reg)
                begin
                    ro_we    = 1'b1;
                    ro_waddr = sh_wr_reg;
                    ro_wdata = ro_q;
                end
                if (!(sh_rd_reg < qlen_reg) && !sh_v_reg)
                begin
                    qlen_next  = qlen_reg - 1'b1;
                    state_next = ST_READ;
                end
            end
            ST_READ:
            begin
                state_next = ST_RES;
            end
            ST_RES:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_task_next   = 4'(chosen_reg);
                    out_cv_next     = valid_reg;
                    out_status_next = status_reg;
                    out_sp_next     = (tid_ok && exists_reg[tid_idx]) ? stat_q : '0;
                    out_cnt_next    = 5'(qlen_reg);
                    state_next      = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            qlen_reg      <= '0;
            next_id_reg   <= '0;
            exists_reg    <= '0;
            queued_reg    <= '0;
            s1_v_reg      <= 1'b0;
            s2_v_reg      <= 1'b0;
            sh_v_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            qlen_reg      <= qlen_next;
            next_id_reg   <= next_id_next;
            exists_reg    <= exists_next;
            queued_reg    <= queued_next;
            s1_v_reg      <= s1_v_next;
            s2_v_reg      <= s2_v_next;
            sh_v_reg      <= sh_v_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        act_reg        <= act_next;
        tid_reg        <= tid_next;
        req_reg        <= req_next;
        chosen_reg     <= chosen_next;
        valid_reg      <= valid_next;
        status_reg     <= status_next;
        issue_reg      <= issue_next;
        s1_pos_reg     <= s1_pos_next;
        s2_pos_reg     <= s2_pos_next;
        s2_tid_reg     <= s2_tid_next;
        best_reg       <= best_next;
        best_pos_reg   <= best_pos_next;
        best_val_reg   <= best_val_next;
        best_stat_reg  <= best_stat_next;
        sh_rd_reg      <= sh_rd_next;
        sh_wr_reg      <= sh_wr_next;
        out_task_reg   <= out_task_next;
        out_cv_reg     <= out_cv_next;
        out_status_reg <= out_status_next;
        out_sp_reg     <= out_sp_next;
        out_cnt_reg    <= out_cnt_next;
    end

    assign sched_in.ready                = (state_reg == ST_IDLE);
    assign sched_out.valid               = out_valid_reg;
    assign sched_out.chosen_task         = out_task_reg;
    assign sched_out.chosen_valid        = out_cv_reg;
    assign sched_out.status              = out_status_reg;
    assign sched_out.static_priority_out = out_sp_reg;
    assign sched_out.ready_count         = out_cnt_reg;
endmodule

[sv/aps_age_unit.sv]
// Aging unit: saturating decrement of a dynamic priority and best-so-far compare.
module aps_age_unit #(
    parameter int DW = 8
) (
    input  logic signed [DW-1:0] cur,
    input  logic signed [DW-1:0] best,
    input  logic                 seed,
    output logic signed [DW-1:0] aged,
    output logic                 take
);
    localparam logic signed [DW-1:0] DYN_MIN = {1'b1, {(DW-1){1'b0}}};
    localparam logic signed [DW-1:0] ONE     = DW'(1);

    assign aged = (cur == DYN_MIN) ? cur : cur - ONE;
    // later task wins a tie
    assign take = seed || (best >= aged);
endmodule

[sv/aps_checker.sv]
// Port-level checks for the aging priority scheduler, bound to the top level.
module aps_checker (
    input logic           clk,
    input logic           rst_n,
    input logic           in_valid,
    input logic           in_ready,
    input logic           out_valid,
    input logic           out_ready,
    input logic [3:0]     chosen_task,
    input logic           chosen_valid,
    input aps_pkg::status_t status,
    input aps_pkg::prio_t static_priority_out,
    input logic [4:0]     ready_count
);
    import aps_pkg::*;

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(chosen_task) && $stable(status)
            && $stable(static_priority_out) && $stable(ready_count))
        else $error("stalled response word changed");

    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        in_valid && in_ready |=> !in_ready)
        else $error("request taken while busy");

    a_no_task_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !chosen_valid |-> chosen_task == 4'd0)
        else $error("meaningless task id not zero");

    a_fail_no_task: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status != STAT_OK |-> !chosen_valid)
        else $error("failed action reports a task");

    a_empty_count: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && status == STAT_EMPTY |-> ready_count == 5'd0)
        else $error("empty pick with nonzero ready count");
endmodule

bind aging_priority_scheduler_unit aps_checker u_aps_checker (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (sched_in.valid),
    .in_ready            (sched_in.ready),
    .out_valid           (sched_out.valid),
    .out_ready           (sched_out.ready),
    .chosen_task         (sched_out.chosen_task),
    .chosen_valid        (sched_out.chosen_valid),
    .status              (sched_out.status),
    .static_priority_out (sched_out.static_priority_out),
    .ready_count         (sched_out.ready_count)
);
